// File: src/lbc_pkg.sv
// lbc_pkg: shared types and constants of the block cache
// used by lbc_front, lbc_back and lru_block_cache_top; no dependencies
package lbc_pkg;

  localparam int MAX_ENTRIES_DEF = 256;
  localparam int BLOCK_WORDS_DEF = 32;
  localparam int TAG_W   = 12;
  localparam int WORD_W  = 64;
  localparam int STAMP_W = 32;
  localparam int CFG_W   = 9;
  localparam int WIDX_W  = 6;
  localparam logic [CFG_W-1:0] ENTRIES_RST = 9'd256;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_UPDATE = 2'd1,
    OP_INSERT = 2'd2,
    OP_BAD    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_DUP  = 2'd2,
    ST_OFF  = 2'd3
  } status_e;

  typedef enum logic {
    CFG_ENABLED = 1'b0,
    CFG_ENTRIES = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DECIDE, S_WDATA, S_RESP, S_STRM_RD, S_STRM_OUT
  } state_e;

  // one classified item in the queue
  typedef struct packed {
    op_e                op;
    logic [TAG_W-1:0]   tag;
    logic [WORD_W-1:0]  word;
    logic               start;
    logic               last;
    logic [WIDX_W-1:0]  widx;
  } item_t;

  // configuration write
  typedef struct packed {
    logic             we;
    cfg_idx_e         idx;
    logic [CFG_W-1:0] data;
  } cfg_wr_t;

endpackage

// File: src/lru_block_cache_top.sv
// lru_block_cache_top: fully associative disk block cache with lru replacement
// depends on lbc_pkg, lbc_front and lbc_back
//
// Input beats carry operation, disk/block tag and a data word on a valid/ready
// channel. A lookup is one beat; update and insert take BLOCK_WORDS beats, the
// first of which decides the outcome. The front frames beats into commands and
// holds up to two beats in a queue; the back runs each command.
// Each command start on an enabled cache, but a bad operation, walks the live
// tag/stamp slots through one memory read port, one slot a cycle. A lookup
// hit then streams BLOCK_WORDS results from the block store, each word read
// into a register before it goes to the output; every other command gives one
// result with last set, on its final beat.
// Results sit in an output register: while the receiver stalls the register
// holds and the back waits, and the queue keeps taking beats until full.
// Reset clears the valid marks, the access clock and the framing counter and
// leaves the cache disabled, its entries setting at 256. Writing the enabled
// register clears all valid marks and the clock; write config only when idle.
module lru_block_cache_top import lbc_pkg::*; #(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int BLOCK_WORDS = BLOCK_WORDS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        operation_i,
  input  logic [3:0]        disk_num_i,
  input  logic [7:0]        block_num_i,
  input  logic [WORD_W-1:0] data_word_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        status_o,
  output logic [WORD_W-1:0] read_word_o,
  output logic              last_o,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [CFG_W-1:0]  cfg_data_i
);

  cfg_wr_t cfg;
  item_t   q_item;
  logic    q_valid, q_ready;

  // configuration write bundle
  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = cfg_idx_e'(cfg_idx_i);
  assign cfg.data = cfg_data_i;

  lbc_front #(
    .BLOCK_WORDS(BLOCK_WORDS)
  ) u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .operation_i,
    .disk_num_i,
    .block_num_i,
    .data_word_i,
    .cfg_i     (cfg),
    .q_valid_o (q_valid),
    .q_ready_i (q_ready),
    .q_item_o  (q_item)
  );

  lbc_back #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .BLOCK_WORDS(BLOCK_WORDS)
  ) u_back (
    .clk_i,
    .rst_ni,
    .q_valid_i (q_valid),
    .q_ready_o (q_ready),
    .q_item_i  (q_item),
    .cfg_i     (cfg),
    .out_valid_o,
    .out_ready_i,
    .status_o,
    .read_word_o,
    .last_o
  );

endmodule

// File: src/lbc_front.sv
// lbc_front: accepts input beats, frames them into commands and queues them
// depends on lbc_pkg
module lbc_front import lbc_pkg::*; #(
  parameter int BLOCK_WORDS = BLOCK_WORDS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        operation_i,
  input  logic [3:0]        disk_num_i,
  input  logic [7:0]        block_num_i,
  input  logic [WORD_W-1:0] data_word_i,
  input  cfg_wr_t           cfg_i,
  output logic              q_valid_o,
  input  logic              q_ready_i,
  output item_t             q_item_o
);

  localparam logic [WIDX_W-1:0] LAST_W = WIDX_W'(BLOCK_WORDS - 1);

  item_t             fifo_q [2];
  logic              wp_q, wp_d, rp_q, rp_d;
  logic [1:0]        cnt_q, cnt_d;
  logic [WIDX_W-1:0] fwc_q, fwc_d;
  item_t             new_item;
  logic              push, pop, cfg_clr;

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign pop        = q_valid_o && q_ready_i;
  assign q_item_o   = fifo_q[rp_q];
  assign cfg_clr    = cfg_i.we && (cfg_i.idx == CFG_ENABLED);

  // command framing: first beat decides, the rest are data words
  always_comb begin
    new_item.op    = op_e'(operation_i);
    new_item.tag   = {disk_num_i, block_num_i};
    new_item.word  = data_word_i;
    new_item.start = (fwc_q == '0);
    new_item.widx  = fwc_q;
    if (fwc_q == '0) begin
      new_item.last = (operation_i == OP_LOOKUP) || (operation_i == OP_BAD) ||
                      (BLOCK_WORDS == 1);
    end else begin
      new_item.last = (fwc_q == LAST_W);
    end
    fwc_d = fwc_q;
    if (cfg_clr) begin
      fwc_d = '0;
    end else if (push) begin
      fwc_d = new_item.last ? '0 : fwc_q + WIDX_W'(1);
    end
    wp_d  = push ? ~wp_q : wp_q;
    rp_d  = pop ? ~rp_q : rp_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  // queue payload
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wp_q] <= new_item;
    end
  end

  // queue pointers and framing counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
      fwc_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
      fwc_q <= fwc_d;
    end
  end

endmodule

// File: src/lbc_back.sv
// lbc_back: tag search, lru choice, block storage and the result register
// depends on lbc_pkg
module lbc_back import lbc_pkg::*; #(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int BLOCK_WORDS = BLOCK_WORDS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  output logic              q_ready_o,
  input  item_t             q_item_i,
  input  cfg_wr_t           cfg_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        status_o,
  output logic [WORD_W-1:0] read_word_o,
  output logic              last_o
);

  localparam int SW      = $clog2(MAX_ENTRIES);
  localparam int SLOT_CW = $clog2(MAX_ENTRIES + 1);
  localparam int CW      = (SLOT_CW > CFG_W) ? SLOT_CW : CFG_W;
  localparam int BAW     = $clog2(MAX_ENTRIES * BLOCK_WORDS);
  localparam int KW      = (BLOCK_WORDS > 1) ? $clog2(BLOCK_WORDS) : 1;
  localparam logic [KW-1:0] K_LAST = KW'(BLOCK_WORDS - 1);

  // storage
  logic [TAG_W-1:0]   tag_mem   [MAX_ENTRIES];
  logic [STAMP_W-1:0] stamp_mem [MAX_ENTRIES];
  logic [WORD_W-1:0]  blk_mem   [MAX_ENTRIES * BLOCK_WORDS];
  logic [MAX_ENTRIES-1:0] valid_q;

  state_e             state_q, state_d;
  item_t              cur_q, cur_d;
  logic               en_q;
  logic [CFG_W-1:0]   ent_q;
  logic [STAMP_W-1:0] time_q, time_d;
  status_e            pend_q, pend_d, resp_q, resp_d;
  logic [SW-1:0]      target_q, target_d;
  logic [KW-1:0]      k_q, k_d;

  // scan pipeline
  logic [SW-1:0]      scan_q, scan_d;
  logic               iss_q, iss_d;
  logic               rd_vld_q, rd_vld_d;
  logic [SW-1:0]      rd_idx_q;
  logic [TAG_W-1:0]   rd_tag_q;
  logic [STAMP_W-1:0] rd_stamp_q;
  logic               rd_valid_q;
  logic               hit_found_q, hit_found_d, free_found_q, free_found_d;
  logic [SW-1:0]      hit_idx_q, hit_idx_d, free_idx_q, free_idx_d, min_idx_q, min_idx_d;
  logic [STAMP_W-1:0] min_stamp_q, min_stamp_d;

  // memory controls
  logic               scan_re, blk_we, blk_re, tag_we, stamp_we, valid_set;
  logic [SW-1:0]      slot_sel;
  logic [BAW-1:0]     blk_waddr, blk_raddr;
  logic [WORD_W-1:0]  blk_rd_q;

  // result register
  logic               out_vld_q, out_load, out_free;
  status_e            out_st_q, out_st_d;
  logic [WORD_W-1:0]  out_word_q, out_word_d;
  logic               out_last_q, out_last_d;

  logic               cfg_clr;
  logic [CW-1:0]      live, last_slot;
  logic [STAMP_W-1:0] time_inc;

  assign cfg_clr   = cfg_i.we && (cfg_i.idx == CFG_ENABLED);
  assign out_free  = !out_vld_q || out_ready_i;
  assign q_ready_o = (state_q == S_IDLE);
  assign time_inc  = (time_q == '1) ? time_q : time_q + STAMP_W'(1);

  // slots in use, clamped to the legal range
  always_comb begin
    if (ent_q < CFG_W'(2)) begin
      live = CW'(2);
    end else if (CW'(ent_q) > CW'(MAX_ENTRIES)) begin
      live = CW'(MAX_ENTRIES);
    end else begin
      live = CW'(ent_q);
    end
    last_slot = live - CW'(1);
  end

  assign blk_waddr = BAW'(target_q) * BAW'(BLOCK_WORDS) + BAW'(cur_q.widx);
  assign blk_raddr = BAW'(target_q) * BAW'(BLOCK_WORDS) + BAW'(k_q);

  // sequencer
  always_comb begin
    state_d      = state_q;
    cur_d        = cur_q;
    time_d       = time_q;
    pend_d       = pend_q;
    resp_d       = resp_q;
    target_d     = target_q;
    k_d          = k_q;
    scan_d       = scan_q;
    iss_d        = iss_q;
    rd_vld_d     = 1'b0;
    hit_found_d  = hit_found_q;
    hit_idx_d    = hit_idx_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    min_idx_d    = min_idx_q;
    min_stamp_d  = min_stamp_q;
    scan_re      = 1'b0;
    blk_we       = 1'b0;
    blk_re       = 1'b0;
    tag_we       = 1'b0;
    stamp_we     = 1'b0;
    valid_set    = 1'b0;
    slot_sel     = hit_idx_q;
    out_load     = 1'b0;
    out_st_d     = ST_OK;
    out_word_d   = '0;
    out_last_d   = 1'b1;

    case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          cur_d        = q_item_i;
          scan_d       = '0;
          iss_d        = 1'b1;
          hit_found_d  = 1'b0;
          free_found_d = 1'b0;
          if (!q_item_i.start) begin
            state_d = S_WDATA;
          end else if (q_item_i.op == OP_BAD) begin
            resp_d  = ST_MISS;
            state_d = S_RESP;
          end else if (!en_q) begin
            if (q_item_i.op == OP_LOOKUP) begin
              resp_d  = ST_OFF;
              state_d = S_RESP;
            end else begin
              pend_d  = ST_OFF;
              state_d = S_WDATA;
            end
          end else begin
            time_d  = time_inc;
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // issue one read per cycle, compare the one read in the previous cycle
        if (iss_q) begin
          scan_re  = 1'b1;
          rd_vld_d = 1'b1;
          if (CW'(scan_q) == last_slot) begin
            iss_d = 1'b0;
          end else begin
            scan_d = scan_q + SW'(1);
          end
        end
        if (rd_vld_q) begin
          if (rd_valid_q && rd_tag_q == cur_q.tag && !hit_found_q) begin
            hit_found_d = 1'b1;
            hit_idx_d   = rd_idx_q;
          end
          if (!rd_valid_q && !free_found_q) begin
            free_found_d = 1'b1;
            free_idx_d   = rd_idx_q;
          end
          if (rd_idx_q == '0 || rd_stamp_q < min_stamp_q) begin
            min_idx_d   = rd_idx_q;
            min_stamp_d = rd_stamp_q;
          end
          if (CW'(rd_idx_q) == last_slot) begin
            state_d = S_DECIDE;
          end
        end
      end
      S_DECIDE: begin
        case (cur_q.op)
          OP_LOOKUP: begin
            if (hit_found_q) begin
              stamp_we = 1'b1;
              target_d = hit_idx_q;
              k_d      = '0;
              state_d  = S_STRM_RD;
            end else begin
              resp_d  = ST_MISS;
              state_d = S_RESP;
            end
          end
          OP_UPDATE: begin
            if (hit_found_q) begin
              stamp_we = 1'b1;
              target_d = hit_idx_q;
              pend_d   = ST_OK;
            end else begin
              pend_d = ST_MISS;
            end
            state_d = S_WDATA;
          end
          default: begin
            if (hit_found_q) begin
              pend_d = ST_DUP;
            end else begin
              slot_sel  = free_found_q ? free_idx_q : min_idx_q;
              stamp_we  = 1'b1;
              tag_we    = 1'b1;
              valid_set = 1'b1;
              target_d  = slot_sel;
              pend_d    = ST_OK;
            end
            state_d = S_WDATA;
          end
        endcase
      end
      S_WDATA: begin
        blk_we = (pend_q == ST_OK);
        if (cur_q.last) begin
          resp_d  = pend_q;
          state_d = S_RESP;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_load = 1'b1;
          out_st_d = resp_q;
          state_d  = S_IDLE;
        end
      end
      S_STRM_RD: begin
        blk_re  = 1'b1;
        state_d = S_STRM_OUT;
      end
      S_STRM_OUT: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_word_d = blk_rd_q;
          out_last_d = (k_q == K_LAST);
          if (k_q == K_LAST) begin
            state_d = S_IDLE;
          end else begin
            k_d     = k_q + KW'(1);
            state_d = S_STRM_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (cfg_clr) begin
      time_d = '0;
    end
  end

  // tag and stamp stores
  always_ff @(posedge clk_i) begin
    if (tag_we) begin
      tag_mem[slot_sel] <= cur_q.tag;
    end
    if (stamp_we) begin
      stamp_mem[slot_sel] <= time_q;
    end
    if (scan_re) begin
      rd_tag_q   <= tag_mem[scan_q];
      rd_stamp_q <= stamp_mem[scan_q];
      rd_valid_q <= valid_q[scan_q];
      rd_idx_q   <= scan_q;
    end
  end

  // block store
  always_ff @(posedge clk_i) begin
    if (blk_we) begin
      blk_mem[blk_waddr] <= cur_q.word;
    end
    if (blk_re) begin
      blk_rd_q <= blk_mem[blk_raddr];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cur_q       <= cur_d;
    target_q    <= target_d;
    k_q         <= k_d;
    scan_q      <= scan_d;
    hit_idx_q   <= hit_idx_d;
    free_idx_q  <= free_idx_d;
    min_idx_q   <= min_idx_d;
    min_stamp_q <= min_stamp_d;
    if (out_load) begin
      out_st_q   <= out_st_d;
      out_word_q <= out_word_d;
      out_last_q <= out_last_d;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      en_q         <= 1'b0;
      ent_q        <= ENTRIES_RST;
      time_q       <= '0;
      pend_q       <= ST_OK;
      resp_q       <= ST_OK;
      iss_q        <= 1'b0;
      rd_vld_q     <= 1'b0;
      hit_found_q  <= 1'b0;
      free_found_q <= 1'b0;
      valid_q      <= '0;
      out_vld_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      time_q       <= time_d;
      pend_q       <= pend_d;
      resp_q       <= resp_d;
      iss_q        <= iss_d;
      rd_vld_q     <= rd_vld_d;
      hit_found_q  <= hit_found_d;
      free_found_q <= free_found_d;
      if (cfg_clr) begin
        en_q    <= cfg_i.data[0];
        valid_q <= '0;
      end else if (valid_set) begin
        valid_q[slot_sel] <= 1'b1;
      end
      if (cfg_i.we && cfg_i.idx == CFG_ENTRIES) begin
        ent_q <= cfg_i.data;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign status_o    = out_st_q;
  assign read_word_o = out_word_q;
  assign last_o      = out_last_q;

  // a search only runs on an enabled cache
  a_scan_enabled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> en_q) else $error("search on disabled cache");

  // an insert into a new slot leaves that slot marked valid
  a_insert_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_set && !cfg_clr) |=> valid_q[target_q]) else $error("insert slot not valid");

  // the access clock only moves forward unless cleared
  a_time_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg_clr |=> (time_q >= $past(time_q))) else $error("time counter went back");

  // no result is loaded over one that waits
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_ready_i) |-> !out_load) else $error("result overwritten");

endmodule
